// ===== rtl/core/multi_stop_gradient_palette_defines.svh =====
// ----------------------------------------------------------------------------
// Gradient palette assertion macros
// Shared property forms for the gradient palette assertions.
// ----------------------------------------------------------------------------
`ifndef MULTI_STOP_GRADIENT_PALETTE_DEFINES_SVH
`define MULTI_STOP_GRADIENT_PALETTE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define MSGP_ASSERT_SAME(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("gradient palette: same-cycle check failed");

// Consequence in the cycle after the condition.
`define MSGP_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("gradient palette: next-cycle check failed");

`endif

// ===== rtl/core/msgp_pkg.sv =====
// ----------------------------------------------------------------------------
// Gradient palette package
// Types, constants and helper functions of the gradient palette generator.
// ----------------------------------------------------------------------------
package msgp_pkg;

   localparam int MaxStops   = 16;
   localparam int MaxEntries = 256;
   localparam int StopIdxW   = $clog2(MaxStops);
   localparam int StopCntW   = $clog2(MaxStops + 1);
   localparam int DivW       = 56;
   localparam int DivCntW    = $clog2(DivW + 1);

   localparam logic signed [31:0] EpsPos    = 32'sd256;
   localparam logic signed [31:0] EpsCol    = 32'sd4096;
   localparam logic signed [31:0] OneColTop = 32'sd16781312;  // one plus epsilon, Q8.24
   localparam logic [14:0]        ByteMul   = 15'd25599;
   localparam logic [15:0]        Recip100  = 16'd41944;     // 2^22 / 100, rounded up

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_START  = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NO_RENDER = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_RANGE_BEGIN = 2'd0,
      CSR_RANGE_END   = 2'd1,
      CSR_ENTRY_COUNT = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CHK, S_ST_DIV, S_NX_RD, S_NX_CMP, S_CR_N,
      S_CR_MA, S_CR_DA, S_CR_WA, S_CR_MB, S_CR_DB, S_CR_WB, S_CV_A, S_CV_B,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [3:0][15:0] right;
      logic [3:0][15:0] left;
      logic [15:0]      pos;
   } stop_entry_type;

   function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
      if (v > 58'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -58'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/core/multi_stop_gradient_palette.sv =====
// ----------------------------------------------------------------------------
// Multi-stop gradient palette
// Sorted color stop table with a palette renderer.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: tuser carries the command (clear, insert stop, start
//    render, next entry), tdata the stop position and its colors.
//  - rsp channel: one transaction per request with status and the four
//    color bytes; tlast marks the final entry of a render.
//  - csr channel: register writes (range begin, range end, entry count),
//    always ready, to be used while the block is idle.
//  - One request is worked at a time. An insert moves each stop that lies
//    above the new position up by one; a start render runs one pass of the
//    shared radix-2 divider.
//  - Every stop crossing of a next entry runs eight divisions through the
//    shared divider, two for each color channel, unless the two stops lie
//    at most one position apart.
//  - The stop table lives in a 16-entry synchronous RAM with a registered
//    read; an insert walks it from the top.
//  - Reset empties the table, ends any render and loads the register
//    defaults. A stalled rsp holds its result in the output register; the
//    next request is taken once the pending result has been loaded there.
// ----------------------------------------------------------------------------
`include "multi_stop_gradient_palette_defines.svh"

module multi_stop_gradient_palette (
   input  logic         clock,
   input  logic         reset,
   // op [1:0]
   input  logic [1:0]   req_tuser,
   // stop_position, left_red, left_green, left_blue, left_alpha,
   // right_red, right_green, right_blue, right_alpha
   input  logic [143:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // status [1:0], red_byte, green_byte, blue_byte, alpha_byte, zero pad
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   msgp_pkg::state_type state_ff, state_in;

   logic [15:0] begin_ff, end_ff;
   logic [8:0]  cfg_count_ff;

   msgp_pkg::stop_entry_type new_ff, new_in, cur_ff, cur_in, nxt_ff, nxt_in;
   msgp_pkg::stop_entry_type mem [msgp_pkg::MaxStops];
   msgp_pkg::stop_entry_type mem_rdata_ff, mem_wdata;
   logic                     mem_we, mem_re;
   logic [msgp_pkg::StopIdxW-1:0] mem_waddr, mem_raddr;

   logic [msgp_pkg::StopCntW-1:0] stop_count_ff, stop_count_in;
   logic [msgp_pkg::StopCntW-1:0] seg_ff, seg_in;
   logic [msgp_pkg::StopIdxW-1:0] at_ff, at_in;
   logic                          active_ff, active_in;
   logic signed [31:0]            walk_ff, walk_in, step_ff, step_in;
   logic [8:0]                    done_ff, done_in;
   logic signed [31:0]            run_ff [4];
   logic signed [31:0]            run_in [4];
   logic signed [31:0]            delta_ff [4];
   logic signed [31:0]            delta_in [4];
   logic signed [32:0]            offset_ff, offset_in;
   logic [15:0]                   diff_ff, diff_in;
   logic [1:0]                    k_ff, k_in;
   logic signed [49:0]            prod_ff, prod_in;
   logic [15:0]                   t_ff, t_in;
   logic [7:0]                    byte_ff [4];
   logic [7:0]                    byte_in [4];
   msgp_pkg::status_type          res_status_ff, res_status_in;
   logic                          res_last_ff, res_last_in;

   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Shared restoring divider: dividend shifts out of quo as quotient bits shift in.
   logic [15:0]                  div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [msgp_pkg::DivW-1:0]    div_quo_ff, div_quo_in;
   logic [msgp_pkg::DivCntW-1:0] div_cnt_ff, div_cnt_in;
   logic                         div_neg_ff, div_neg_in;
   logic                         div_start;
   logic signed [msgp_pkg::DivW-1:0] div_num;
   logic [15:0]                  div_den;
   logic [16:0]                  rem_sh;
   logic                         rem_ge;
   logic signed [msgp_pkg::DivW:0] div_q;

   logic [8:0]         eff_count;
   logic               fwd;
   logic [15:0]        base_c, tgt_c;
   logic signed [16:0] d_c;
   logic signed [32:0] mul_b;
   logic signed [49:0] prod_w;
   logic signed [57:0] base_wide;
   logic signed [16:0] span;
   logic [msgp_pkg::StopCntW-1:0] seg_plus, n_idx;
   logic signed [32:0] walk_ext, pos_ext;
   logic signed [31:0] v_c;
   logic [24:0]        vc;
   logic [39:0]        cv_prod;
   logic [31:0]        q_prod;
   logic [9:0]         q_byte;

   assign req_tready = (state_ff == msgp_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // Shared datapath terms.
   always_comb begin
      eff_count = cfg_count_ff;
      if (cfg_count_ff == 9'd0) begin
         eff_count = 9'd1;
      end else if (cfg_count_ff > 9'(msgp_pkg::MaxEntries)) begin
         eff_count = 9'(msgp_pkg::MaxEntries);
      end
      fwd       = (step_ff > msgp_pkg::EpsPos);
      base_c    = fwd ? cur_ff.right[k_ff] : cur_ff.left[k_ff];
      tgt_c     = fwd ? nxt_ff.left[k_ff] : nxt_ff.right[k_ff];
      d_c       = $signed({tgt_c[15], tgt_c}) - $signed({base_c[15], base_c});
      mul_b     = (state_ff == msgp_pkg::S_CR_MA) ? offset_ff : $signed({step_ff[31], step_ff});
      prod_w    = d_c * mul_b;
      base_wide = $signed({{30{base_c[15]}}, base_c, 12'd0});
      span      = $signed({end_ff[15], end_ff}) - $signed({begin_ff[15], begin_ff});
      seg_plus  = seg_ff + 1'b1;
      n_idx     = (seg_plus < stop_count_ff) ? seg_plus : seg_ff;
      walk_ext  = $signed({walk_ff[31], walk_ff});
      pos_ext   = $signed({{9{mem_rdata_ff.pos[15]}}, mem_rdata_ff.pos, 8'd0});
      v_c       = run_ff[k_ff];
      vc        = (v_c > msgp_pkg::OneColTop) ? 25'h1000000 : v_c[24:0];
      cv_prod   = vc * msgp_pkg::ByteMul;
      q_prod    = t_ff * msgp_pkg::Recip100;
      q_byte    = q_prod[31:22];
      rem_sh    = {div_rem_ff, div_quo_ff[msgp_pkg::DivW-1]};
      rem_ge    = (rem_sh >= {1'b0, div_den_ff});
      div_q     = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
   end

   always_comb begin
      state_in      = state_ff;
      new_in        = new_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      stop_count_in = stop_count_ff;
      seg_in        = seg_ff;
      at_in         = at_ff;
      active_in     = active_ff;
      walk_in       = walk_ff;
      step_in       = step_ff;
      done_in       = done_ff;
      run_in        = run_ff;
      delta_in      = delta_ff;
      offset_in     = offset_ff;
      diff_in       = diff_ff;
      k_in          = k_ff;
      prod_in       = prod_ff;
      t_in          = t_ff;
      byte_in       = byte_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = new_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;

      case (state_ff)
         msgp_pkg::S_IDLE: begin
            if (req_tvalid) begin
               new_in        = msgp_pkg::stop_entry_type'(req_tdata);
               for (int j = 0; j < 4; j++) begin
                  byte_in[j] = 8'd0;
               end
               res_status_in = msgp_pkg::STAT_OK;
               res_last_in   = 1'b0;
               state_in      = msgp_pkg::S_RESP;
               case (msgp_pkg::op_type'(req_tuser))
                  msgp_pkg::OP_CLEAR: begin
                     stop_count_in = '0;
                     active_in     = 1'b0;
                  end
                  msgp_pkg::OP_INSERT: begin
                     active_in = 1'b0;
                     if (stop_count_ff == msgp_pkg::StopCntW'(msgp_pkg::MaxStops)) begin
                        res_status_in = msgp_pkg::STAT_FULL;
                     end else begin
                        at_in    = stop_count_ff[msgp_pkg::StopIdxW-1:0];
                        state_in = msgp_pkg::S_INS_RD;
                     end
                  end
                  msgp_pkg::OP_START: begin
                     if (stop_count_ff == '0) begin
                        active_in     = 1'b0;
                        res_status_in = msgp_pkg::STAT_EMPTY;
                     end else begin
                        div_start = 1'b1;
                        div_num   = msgp_pkg::DivW'($signed({span, 8'd0}));
                        div_den   = {7'd0, eff_count};
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = msgp_pkg::S_ST_DIV;
                     end
                  end
                  msgp_pkg::OP_NEXT: begin
                     if (!active_ff) begin
                        res_status_in = msgp_pkg::STAT_NO_RENDER;
                     end else begin
                        state_in = msgp_pkg::S_NX_RD;
                     end
                  end
                  default: begin
                     state_in = msgp_pkg::S_RESP;
                  end
               endcase
            end
         end
         // Insertion sort: move stops up while they lie above the new position.
         msgp_pkg::S_INS_RD: begin
            if (at_ff == '0) begin
               mem_we        = 1'b1;
               mem_waddr     = '0;
               stop_count_in = stop_count_ff + 1'b1;
               state_in      = msgp_pkg::S_RESP;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = at_ff - 1'b1;
               state_in  = msgp_pkg::S_INS_CHK;
            end
         end
         msgp_pkg::S_INS_CHK: begin
            mem_we    = 1'b1;
            mem_waddr = at_ff;
            if ($signed(mem_rdata_ff.pos) > $signed(new_ff.pos)) begin
               mem_wdata = mem_rdata_ff;
               at_in     = at_ff - 1'b1;
               state_in  = msgp_pkg::S_INS_RD;
            end else begin
               stop_count_in = stop_count_ff + 1'b1;
               state_in      = msgp_pkg::S_RESP;
            end
         end
         msgp_pkg::S_ST_DIV: begin
            if (div_cnt_ff == '0) begin
               step_in = div_q[31:0];
               walk_in = $signed({{8{begin_ff[15]}}, begin_ff, 8'd0});
               for (int j = 0; j < 4; j++) begin
                  run_in[j]   = $signed({{4{mem_rdata_ff.left[j][15]}},
                                         mem_rdata_ff.left[j], 12'd0});
                  delta_in[j] = '0;
               end
               seg_in    = '0;
               done_in   = '0;
               active_in = 1'b1;
               state_in  = msgp_pkg::S_RESP;
            end
         end
         msgp_pkg::S_NX_RD: begin
            k_in = '0;
            if (seg_ff < stop_count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = seg_ff[msgp_pkg::StopIdxW-1:0];
               state_in  = msgp_pkg::S_NX_CMP;
            end else begin
               state_in = msgp_pkg::S_CV_A;
            end
         end
         msgp_pkg::S_NX_CMP: begin
            if (walk_ext >= pos_ext) begin
               cur_in    = mem_rdata_ff;
               seg_in    = seg_plus;
               mem_re    = 1'b1;
               mem_raddr = n_idx[msgp_pkg::StopIdxW-1:0];
               state_in  = msgp_pkg::S_CR_N;
            end else begin
               state_in = msgp_pkg::S_CV_A;
            end
         end
         msgp_pkg::S_CR_N: begin
            nxt_in    = mem_rdata_ff;
            offset_in = walk_ext - $signed({{9{cur_ff.pos[15]}}, cur_ff.pos, 8'd0});
            diff_in   = 16'($signed({mem_rdata_ff.pos[15], mem_rdata_ff.pos})
                            - $signed({cur_ff.pos[15], cur_ff.pos}));
            k_in      = '0;
            state_in  = msgp_pkg::S_CR_MA;
         end
         msgp_pkg::S_CR_MA: begin
            if (diff_ff > 16'd1) begin
               prod_in  = prod_w;
               state_in = msgp_pkg::S_CR_DA;
            end else begin
               // Stops at most one position apart: hold the base color.
               run_in[k_ff]   = base_wide[31:0];
               delta_in[k_ff] = '0;
               k_in           = k_ff + 1'b1;
               if (k_ff == 2'd3) begin
                  state_in = msgp_pkg::S_NX_RD;
               end
            end
         end
         msgp_pkg::S_CR_DA, msgp_pkg::S_CR_DB: begin
            div_start = 1'b1;
            div_num   = $signed({{2{prod_ff[49]}}, prod_ff, 4'd0});
            div_den   = diff_ff;
            state_in  = (state_ff == msgp_pkg::S_CR_DA) ? msgp_pkg::S_CR_WA
                                                         : msgp_pkg::S_CR_WB;
         end
         msgp_pkg::S_CR_WA: begin
            if (div_cnt_ff == '0) begin
               run_in[k_ff] = msgp_pkg::sat32(base_wide + 58'(div_q));
               state_in     = msgp_pkg::S_CR_MB;
            end
         end
         msgp_pkg::S_CR_MB: begin
            prod_in  = prod_w;
            state_in = msgp_pkg::S_CR_DB;
         end
         msgp_pkg::S_CR_WB: begin
            if (div_cnt_ff == '0) begin
               delta_in[k_ff] = msgp_pkg::sat32(58'(div_q));
               k_in           = k_ff + 1'b1;
               state_in       = (k_ff == 2'd3) ? msgp_pkg::S_NX_RD : msgp_pkg::S_CR_MA;
            end
         end
         msgp_pkg::S_CV_A: begin
            t_in     = (v_c < msgp_pkg::EpsCol) ? 16'd0 : cv_prod[39:24];
            state_in = msgp_pkg::S_CV_B;
         end
         msgp_pkg::S_CV_B: begin
            byte_in[k_ff] = (q_byte > 10'd255) ? 8'd255 : q_byte[7:0];
            run_in[k_ff]  = msgp_pkg::sat32(58'(run_ff[k_ff]) + 58'(delta_ff[k_ff]));
            k_in          = k_ff + 1'b1;
            state_in      = msgp_pkg::S_CV_A;
            if (k_ff == 2'd3) begin
               walk_in       = msgp_pkg::sat32(58'(walk_ff) + 58'(step_ff));
               done_in       = done_ff + 1'b1;
               res_status_in = msgp_pkg::STAT_OK;
               if (done_ff + 1'b1 >= eff_count) begin
                  res_last_in = 1'b1;
                  active_in   = 1'b0;
               end
               state_in = msgp_pkg::S_RESP;
            end
         end
         msgp_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {6'd0, byte_ff[3], byte_ff[2], byte_ff[1], byte_ff[0],
                               res_status_ff};
               rsp_last_in  = res_last_ff;
               rsp_valid_in = 1'b1;
               state_in     = msgp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msgp_pkg::S_IDLE;
         end
      endcase

      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      div_neg_in = div_neg_ff;
      div_cnt_in = div_cnt_ff;
      if (div_start) begin
         div_rem_in = '0;
         div_quo_in = div_num[msgp_pkg::DivW-1] ? msgp_pkg::DivW'(-div_num)
                                                : msgp_pkg::DivW'(div_num);
         div_den_in = div_den;
         div_neg_in = div_num[msgp_pkg::DivW-1];
         div_cnt_in = msgp_pkg::DivCntW'(msgp_pkg::DivW);
      end else if (div_cnt_ff != '0) begin
         div_rem_in = rem_ge ? 16'(rem_sh - {1'b0, div_den_ff}) : rem_sh[15:0];
         div_quo_in = {div_quo_ff[msgp_pkg::DivW-2:0], rem_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msgp_pkg::S_IDLE;
         begin_ff      <= 16'd0;
         end_ff        <= 16'd4096;
         cfg_count_ff  <= 9'd256;
         stop_count_ff <= '0;
         seg_ff        <= '0;
         active_ff     <= 1'b0;
         done_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         stop_count_ff <= stop_count_in;
         seg_ff        <= seg_in;
         active_ff     <= active_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_cnt_ff    <= div_cnt_in;
         if (csr_valid) begin
            case (msgp_pkg::csr_type'(csr_index))
               msgp_pkg::CSR_RANGE_BEGIN: begin
                  begin_ff <= csr_data;
               end
               msgp_pkg::CSR_RANGE_END: begin
                  end_ff <= csr_data;
               end
               msgp_pkg::CSR_ENTRY_COUNT: begin
                  cfg_count_ff <= csr_data[8:0];
               end
               default: begin
                  cfg_count_ff <= cfg_count_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      new_ff        <= new_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      at_ff         <= at_in;
      walk_ff       <= walk_in;
      step_ff       <= step_in;
      run_ff        <= run_in;
      delta_ff      <= delta_in;
      offset_ff     <= offset_in;
      diff_ff       <= diff_in;
      k_ff          <= k_in;
      prod_ff       <= prod_in;
      t_ff          <= t_in;
      byte_ff       <= byte_in;
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_den_ff    <= div_den_in;
      div_neg_ff    <= div_neg_in;
   end

   `MSGP_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      stop_count_ff <= msgp_pkg::StopCntW'(msgp_pkg::MaxStops))
   `MSGP_ASSERT_SAME(a_seg_bound, clock, reset, active_ff, seg_ff <= stop_count_ff)
   `MSGP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      state_ff != msgp_pkg::S_IDLE)
   `MSGP_ASSERT_SAME(a_div_owner, clock, reset, div_cnt_ff != '0,
      state_ff == msgp_pkg::S_ST_DIV || state_ff == msgp_pkg::S_CR_WA ||
      state_ff == msgp_pkg::S_CR_WB)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient palette testbench
// Drives stop-table commands and palette renders into the gradient palette
// block and checks every response against a built-in predictor.
// ----------------------------------------------------------------------------

typedef struct {
   logic [1:0] status;
   logic [7:0] chan [4];
   logic       last;
} palette_rsp_type;

class palette_board;
   // Predicted block state.
   int       rbegin;
   int       rend;
   int       ecount;
   int       spos [16];
   int       sleft [16][4];
   int       sright [16][4];
   int       nstops;
   int       seg;
   int       rcol [4];
   int       dcol [4];
   int       walk;
   int       pstep;
   int       done;
   bit       active;
   palette_rsp_type pending [$];
   int       mismatches;
   int       checked;
   int       entries_seen;

   function new();
      rbegin = 0;
      rend = 4096;
      ecount = 256;
      nstops = 0;
      seg = 0;
      walk = 0;
      pstep = 0;
      done = 0;
      active = 0;
      mismatches = 0;
      checked = 0;
      entries_seen = 0;
      for (int k = 0; k < 4; k++) begin
         rcol[k] = 0;
         dcol[k] = 0;
      end
   endfunction

   function void write_reg(msgp_pkg::csr_type idx, logic [15:0] val);
      case (idx)
         msgp_pkg::CSR_RANGE_BEGIN: rbegin = $signed(val);
         msgp_pkg::CSR_RANGE_END:   rend = $signed(val);
         default:                   ecount = val[8:0];
      endcase
   endfunction

   function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function int used_count();
      if (ecount < 1) return 1;
      if (ecount > msgp_pkg::MaxEntries) return msgp_pkg::MaxEntries;
      return ecount;
   endfunction

   function logic [7:0] color_byte(int x);
      longint v;
      longint b;
      v = x;
      if (v < 4096) return 0;
      if (v - 64'sd16777216 > 4096) v = 64'sd16777216;
      b = (v * 25599) / (64'sd100 * 64'sd16777216);
      if (b > 255) b = 255;
      return b[7:0];
   endfunction

   // Reload the running color and delta when the walk passes a stop.
   function void cross_stop();
      int     c;
      int     n;
      bit     fwd;
      longint diff;
      longint offs;
      longint base;
      longint tgt;
      longint d;
      c = seg;
      fwd = pstep > 256;
      seg = c + 1;
      n = (seg < nstops) ? seg : c;
      diff = longint'(spos[n]) - longint'(spos[c]);
      offs = longint'(walk) - longint'(spos[c]) * 256;
      for (int k = 0; k < 4; k++) begin
         base = fwd ? sright[c][k] : sleft[c][k];
         tgt = fwd ? sleft[n][k] : sright[n][k];
         d = tgt - base;
         if (diff > 1 || diff < -1) begin
            rcol[k] = clip32(base * 4096 + (d * offs * 16) / diff);
            dcol[k] = clip32((d * longint'(pstep) * 16) / diff);
         end else begin
            rcol[k] = int'(base * 4096);
            dcol[k] = 0;
         end
      end
   endfunction

   function void note_request(msgp_pkg::op_type op, logic [143:0] data);
      palette_rsp_type r;
      int         p;
      int         at;
      longint     span;
      r.status = msgp_pkg::STAT_OK;
      r.last = 0;
      for (int k = 0; k < 4; k++) r.chan[k] = 0;
      case (op)
         msgp_pkg::OP_CLEAR: begin
            nstops = 0;
            active = 0;
         end
         msgp_pkg::OP_INSERT: begin
            active = 0;
            if (nstops >= msgp_pkg::MaxStops) begin
               r.status = msgp_pkg::STAT_FULL;
            end else begin
               p = $signed(data[15:0]);
               at = nstops;
               while (at > 0 && spos[at-1] > p) at--;
               for (int i = nstops; i > at; i--) begin
                  spos[i] = spos[i-1];
                  sleft[i] = sleft[i-1];
                  sright[i] = sright[i-1];
               end
               spos[at] = p;
               for (int k = 0; k < 4; k++) begin
                  sleft[at][k] = $signed(data[16*(1+k) +: 16]);
                  sright[at][k] = $signed(data[16*(5+k) +: 16]);
               end
               nstops++;
            end
         end
         msgp_pkg::OP_START: begin
            if (nstops == 0) begin
               active = 0;
               r.status = msgp_pkg::STAT_EMPTY;
            end else begin
               span = longint'(rend) - longint'(rbegin);
               pstep = int'((span * 256) / used_count());
               walk = rbegin * 256;
               for (int k = 0; k < 4; k++) begin
                  rcol[k] = sleft[0][k] * 4096;
                  dcol[k] = 0;
               end
               seg = 0;
               done = 0;
               active = 1;
            end
         end
         default: begin
            if (!active) begin
               r.status = msgp_pkg::STAT_NO_RENDER;
            end else begin
               while (seg < nstops && longint'(walk) >= longint'(spos[seg]) * 256)
                  cross_stop();
               for (int k = 0; k < 4; k++) begin
                  r.chan[k] = color_byte(rcol[k]);
                  rcol[k] = clip32(longint'(rcol[k]) + dcol[k]);
               end
               walk = clip32(longint'(walk) + pstep);
               done++;
               entries_seen++;
               if (done >= used_count()) begin
                  r.last = 1;
                  active = 0;
               end
            end
         end
      endcase
      pending.push_back(r);
   endfunction

   function void check_response(logic [39:0] data, logic last);
      palette_rsp_type e;
      bit         bad;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: response with none expected: %h", data);
         return;
      end
      e = pending.pop_front();
      bad = data[1:0] != e.status || last != e.last;
      for (int k = 0; k < 4; k++) if (data[2+8*k +: 8] != e.chan[k]) bad = 1;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp st=%0d rgba=%h %h %h %h last=%0b, got %h last=%0b",
               e.status, e.chan[0], e.chan[1], e.chan[2], e.chan[3], e.last, data, last);
      end
   endfunction
endclass

module tb;
   logic         clock = 0;
   logic         reset = 1;
   logic [1:0]   req_tuser = 0;
   logic [143:0] req_tdata = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [39:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = 0;
   logic [15:0]  csr_data = 0;

   palette_board board = new();
   int           cycles = 0;
   int           burst_left = 0;
   bit           hold_off = 0;
   bit           stalls_on = 1;
   int           sent = 0;
   bit           req_on = 0;
   bit           csr_on = 0;

   multi_stop_gradient_palette u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 6000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stall pattern, with a long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tlast);
      if (hold_off) rsp_tready <= 0;
      else if (!stalls_on) rsp_tready <= 1;
      else rsp_tready <= (($urandom >> 4) % 8) < 5;
   end

   task automatic req_idle();
      if (req_on) begin
         req_tvalid <= 0;
         req_on = 0;
      end
   endtask

   task automatic csr_idle();
      if (csr_on) begin
         csr_valid <= 0;
         csr_on = 0;
      end
   endtask

   task automatic send(msgp_pkg::op_type op, logic [143:0] data);
      int gap;
      csr_idle();
      // Burst gaps: random idle stretches between runs of requests.
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_idle();
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_on = 1;
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, data);
      sent++;
   endtask

   task automatic drain();
      req_idle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(msgp_pkg::csr_type idx, logic [15:0] val);
      csr_on = 1;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
   endtask

   function automatic logic [15:0] rnd_color();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h1000;
         default: return 16'($urandom_range(0, 16'h1400)) - 16'h0100;
      endcase
   endfunction

   function automatic logic [143:0] stop_data(logic [15:0] p, bit wild);
      logic [143:0] d;
      d[15:0] = p;
      for (int k = 1; k < 9; k++) d[16*k +: 16] = wild ? 16'($urandom) : rnd_color();
      return d;
   endfunction

   function automatic logic [15:0] rnd_pos();
      return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h1400)) - 16'h0200;
   endfunction

   task automatic config_phase();
      int sel;
      drain();
      sel = $urandom_range(0, 5);
      case (sel)
         0: begin
            write_csr(msgp_pkg::CSR_RANGE_BEGIN, 16'd0);
            write_csr(msgp_pkg::CSR_RANGE_END, 16'h1000);
         end
         1: begin
            write_csr(msgp_pkg::CSR_RANGE_BEGIN, 16'h1000);
            write_csr(msgp_pkg::CSR_RANGE_END, 16'd0);
         end
         2: begin
            write_csr(msgp_pkg::CSR_RANGE_BEGIN, 16'h8000);
            write_csr(msgp_pkg::CSR_RANGE_END, 16'h7fff);
         end
         default: begin
            write_csr(msgp_pkg::CSR_RANGE_BEGIN, rnd_pos());
            write_csr(msgp_pkg::CSR_RANGE_END, rnd_pos());
         end
      endcase
      case ($urandom_range(0, 7))
         0: write_csr(msgp_pkg::CSR_ENTRY_COUNT, 16'd0);
         1: write_csr(msgp_pkg::CSR_ENTRY_COUNT, 16'h01ff);
         2: write_csr(msgp_pkg::CSR_ENTRY_COUNT, 16'd256);
         3: write_csr(msgp_pkg::CSR_ENTRY_COUNT, 16'd1);
         default: write_csr(msgp_pkg::CSR_ENTRY_COUNT, 16'($urandom_range(2, 24)));
      endcase
   endtask

   initial begin
      int nstop;
      int nent;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty-table and no-render answers, extremes, full table.
      write_csr(msgp_pkg::CSR_ENTRY_COUNT, 16'd4);
      send(msgp_pkg::OP_NEXT, '0);
      send(msgp_pkg::OP_START, '0);
      send(msgp_pkg::OP_CLEAR, {144{1'b1}});
      send(msgp_pkg::OP_INSERT, stop_data(16'h1000, 0));
      send(msgp_pkg::OP_INSERT, stop_data(16'h0000, 1));
      send(msgp_pkg::OP_INSERT, stop_data(16'h0000, 0));
      send(msgp_pkg::OP_INSERT, {{128{1'b1}}, 16'h8000});
      send(msgp_pkg::OP_INSERT, {{128{1'b0}}, 16'h7fff});
      send(msgp_pkg::OP_START, '0);
      repeat (5) send(msgp_pkg::OP_NEXT, '0);
      for (int i = 0; i < 12; i++) send(msgp_pkg::OP_INSERT, stop_data(rnd_pos(), 0));
      send(msgp_pkg::OP_INSERT, stop_data(16'd0, 0));
      drain();
      // Backward walk over the full table.
      write_csr(msgp_pkg::CSR_RANGE_BEGIN, 16'h1000);
      write_csr(msgp_pkg::CSR_RANGE_END, 16'h0000);
      send(msgp_pkg::OP_START, '0);
      repeat (4) send(msgp_pkg::OP_NEXT, '0);

      // Long receiver hold-off so requests back up.
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
      join_none
      repeat (3) send(msgp_pkg::OP_NEXT, '0);
      req_idle();
      wait (!hold_off);
      drain();

      // Random sessions: build a table, render, with some noise.
      while (sent < 1950) begin
         if ($urandom_range(0, 3) == 0) config_phase();
         stalls_on = $urandom_range(0, 4) != 0;
         send(msgp_pkg::OP_CLEAR, 144'($urandom));
         nstop = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(1, 5);
         for (int i = 0; i < nstop; i++)
            send(msgp_pkg::OP_INSERT, stop_data(rnd_pos(), $urandom_range(0, 7) == 0));
         send(msgp_pkg::OP_START, '0);
         nent = $urandom_range(1, 30);
         for (int i = 0; i < nent; i++) begin
            if ($urandom_range(0, 40) == 0)
               send(msgp_pkg::op_type'($urandom_range(0, 2)), stop_data(rnd_pos(), 1));
            else send(msgp_pkg::OP_NEXT, 144'($urandom));
         end
      end
      drain();
      $display("Ran %0d requests with %0d checked responses, %0d palette entries.",
         sent, board.checked, board.entries_seen);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
